// File: design/sln_pkg.sv
// sln_pkg: shared types and constants for the sequence length statistics block
// used by sequence_length_nstats and its checker
`timescale 1ns / 1ps
package sln_pkg;

  localparam int unsigned DefMaxRecords = 4096;
  localparam int unsigned DefLengthBits = 32;

  // fixed field widths of the result item
  localparam int unsigned CountOutW = 13;
  localparam int unsigned SumOutW   = 44;
  localparam int unsigned LenOutW   = 32;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 264;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SO_START,
    ST_SO_VRD,
    ST_SO_JCHK,
    ST_SO_JRD,
    ST_SC_RD,
    ST_SC_EV,
    ST_SC_CHK,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// File: design/sln_ram.sv
// sln_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module sln_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/sequence_length_nstats.sv
// load accepts one request per cycle; on last the block sorts the stored lengths in place
// (insertion sort using the ram's one write and one read port), scans the records in order,
// then runs a restoring division that rounds the sum of squares over the total
// throughput: one set at a time; s_axis_tready is high only in the load phase
// reset: asynchronous active low, clears counters and statistics; the ram needs no clearing
// depends on sln_pkg and sln_ram
`timescale 1ns / 1ps
module sequence_length_nstats
  import sln_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = DefMaxRecords,
  parameter int unsigned LENGTH_BITS = DefLengthBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // seq_length
  input  logic                s_axis_tuser_i,  // has_length
  input  logic                s_axis_tlast_i,  // last
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // record_total[12:0], length_sum[56:13], n50_length[88:57], n75_length[120:89],
  // n90_length[152:121], l50_count[165:153], shortest[197:166], longest[229:198],
  // area_under_nx[261:230], overflowed[262], zero pad[263]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AW  = $clog2(MAX_RECORDS);
  localparam int unsigned CW  = $clog2(MAX_RECORDS + 1);
  localparam int unsigned L   = LENGTH_BITS;
  localparam int unsigned TW  = L + AW;
  localparam int unsigned SW  = 2 * L + AW;
  localparam int unsigned NW  = SW + 2;
  localparam int unsigned RW  = TW + 2;
  localparam int unsigned KW  = $clog2(NW + 1);

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d, i_q, i_d, j_q, j_d;
  logic [TW-1:0] total_q, total_d, sum_q, sum_d;
  logic [L-1:0]  min_q, min_d, max_q, max_d, v_q, v_d;
  logic [L-1:0]  n50_q, n50_d, n75_q, n75_d, n90_q, n90_d;
  logic [CW-1:0] l50_q, l50_d;
  logic          f50_q, f50_d, f75_q, f75_d, f90_q, f90_d, drop_q, drop_d;
  logic [2*L-1:0] sq_q, sq_d;
  logic [SW-1:0] acc_q, acc_d;
  logic [NW-1:0] num_q, num_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [31:0]   quo_q, quo_d;
  logic [KW-1:0] cnt_q, cnt_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [L-1:0]  wdata, rdata, in_len;
  logic          in_acc;
  logic [CW-1:0] jm1, ip1;

  // threshold and divider datapath
  logic [TW+4:0] sum_x, tot_x;
  logic          c50, c75, c90;
  logic [RW-1:0] rem_sh, div_d;
  logic          q_bit;

  sln_ram #(.Width(L), .Depth(MAX_RECORDS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_len = s_axis_tdata_i[L-1:0];
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign jm1    = j_q - 1'b1;
  assign ip1    = i_q + 1'b1;

  // exact threshold tests on the running sum
  assign sum_x = (TW+5)'(sum_q);
  assign tot_x = (TW+5)'(total_q);
  assign c50 = (sum_x << 1) >= tot_x;
  assign c75 = (sum_x << 2) >= ((tot_x << 1) + tot_x);
  assign c90 = ((sum_x << 3) + (sum_x << 1)) >= ((tot_x << 3) + tot_x);

  // one restoring division step
  assign rem_sh = {rem_q[RW-2:0], num_q[NW-1]};
  assign div_d  = {1'b0, total_q, 1'b0};
  assign q_bit  = rem_sh >= div_d;

  // next state and datapath
  always_comb begin
    state_d = state_q;
    count_d = count_q; i_d = i_q; j_d = j_q;
    total_d = total_q; sum_d = sum_q;
    min_d = min_q; max_d = max_q; v_d = v_q;
    n50_d = n50_q; n75_d = n75_q; n90_d = n90_q; l50_d = l50_q;
    f50_d = f50_q; f75_d = f75_q; f90_d = f90_q; drop_d = drop_q;
    sq_d = sq_q; acc_d = acc_q; num_d = num_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q;
    we = 1'b0; waddr = count_q[AW-1:0]; wdata = in_len; raddr = i_q[AW-1:0];
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            if (count_q < CW'(MAX_RECORDS)) begin
              we      = 1'b1;
              count_d = count_q + 1'b1;
              total_d = total_q + TW'(in_len);
              if (in_len < min_q) min_d = in_len;
              if (in_len > max_q) max_d = in_len;
            end else begin
              drop_d = 1'b1;
            end
          end
          if (s_axis_tlast_i) begin
            i_d     = CW'(1);
            state_d = ST_SO_START;
          end
        end
      end
      ST_SO_START: begin
        if (i_q >= count_q) begin
          i_d     = '0;
          state_d = ST_SC_RD;
        end else begin
          state_d = ST_SO_VRD;
        end
      end
      ST_SO_VRD: begin
        v_d     = rdata;
        j_d     = i_q;
        state_d = ST_SO_JCHK;
      end
      ST_SO_JCHK: begin
        raddr = jm1[AW-1:0];
        if (j_q == '0) begin
          we = 1'b1; waddr = '0; wdata = v_q;
          i_d = ip1;
          state_d = ST_SO_START;
        end else begin
          state_d = ST_SO_JRD;
        end
      end
      ST_SO_JRD: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
        if (rdata < v_q) begin
          wdata   = rdata;
          j_d     = jm1;
          state_d = ST_SO_JCHK;
        end else begin
          wdata   = v_q;
          i_d     = ip1;
          state_d = ST_SO_START;
        end
      end
      ST_SC_RD: begin
        if (i_q >= count_q) begin
          num_d = ({acc_q, 1'b0} + NW'(total_q)) ;
          rem_d = '0;
          quo_d = '0;
          cnt_d = KW'(NW);
          state_d = (total_q == '0) ? ST_OUT : ST_DIV;
        end else begin
          state_d = ST_SC_EV;
        end
      end
      ST_SC_EV: begin
        v_d     = rdata;
        sum_d   = sum_q + TW'(rdata);
        sq_d    = (2*L)'(rdata) * (2*L)'(rdata);
        state_d = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        acc_d = acc_q + SW'(sq_q);
        if (!f50_q && c50) begin
          f50_d = 1'b1; n50_d = v_q; l50_d = ip1;
        end
        if (!f75_q && c75) begin
          f75_d = 1'b1; n75_d = v_q;
        end
        if (!f90_q && c90) begin
          f90_d = 1'b1; n90_d = v_q;
        end
        i_d     = ip1;
        state_d = ST_SC_RD;
      end
      ST_DIV: begin
        rem_d = q_bit ? (rem_sh - div_d) : rem_sh;
        quo_d = {quo_q[30:0], q_bit};
        num_d = num_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == KW'(1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          count_d = '0; total_d = '0; sum_d = '0; acc_d = '0;
          min_d = '1; max_d = '0; drop_d = 1'b0;
          f50_d = 1'b0; f75_d = 1'b0; f90_d = 1'b0;
          n50_d = '0; n75_d = '0; n90_d = '0; l50_d = '0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0; total_q <= '0; sum_q <= '0; acc_q <= '0;
      min_q <= '1; max_q <= '0; drop_q <= 1'b0;
      f50_q <= 1'b0; f75_q <= 1'b0; f90_q <= 1'b0;
      n50_q <= '0; n75_q <= '0; n90_q <= '0; l50_q <= '0;
      i_q <= '0; j_q <= '0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d; total_q <= total_d; sum_q <= sum_d; acc_q <= acc_d;
      min_q <= min_d; max_q <= max_d; drop_q <= drop_d;
      f50_q <= f50_d; f75_q <= f75_d; f90_q <= f90_d;
      n50_q <= n50_d; n75_q <= n75_d; n90_q <= n90_d; l50_q <= l50_d;
      i_q <= i_d; j_q <= j_d; cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    v_q <= v_d; sq_q <= sq_d; num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
  end

  // result packing
  logic [CW+CountOutW-1:0] cnt_ext, l50_ext;
  logic [TW+SumOutW-1:0]   tot_ext;
  logic                    empty;
  assign cnt_ext = (CW+CountOutW)'(count_q);
  assign l50_ext = (CW+CountOutW)'(l50_q);
  assign tot_ext = (TW+SumOutW)'(total_q);
  assign empty   = (count_q == '0);

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o = {
    1'b0,
    drop_q,
    (total_q == '0) ? 32'd0 : quo_q,
    empty ? LenOutW'(0) : LenOutW'(max_q),
    empty ? LenOutW'(0) : LenOutW'(min_q),
    l50_ext[CountOutW-1:0],
    LenOutW'(n90_q),
    LenOutW'(n75_q),
    LenOutW'(n50_q),
    tot_ext[SumOutW-1:0],
    cnt_ext[CountOutW-1:0]
  };

endmodule

// File: design/sln_checker.sv
// sln_checker: port-level assertions for sequence_length_nstats, bound to the top level
// depends on sln_pkg
`timescale 1ns / 1ps
module sln_checker
  import sln_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = DefMaxRecords
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // no request taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("ready while result pending");

  // after a result is taken the block loads again
  a_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=> s_axis_tready_o && !m_axis_tvalid_o)
    else $error("no return to load");

  // count never exceeds capacity, rank never exceeds count
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[12:0] <= 13'(MAX_RECORDS)
      && m_axis_tdata_o[165:153] <= m_axis_tdata_o[12:0])
    else $error("bad record count");

endmodule

bind sequence_length_nstats sln_checker #(.MAX_RECORDS(MAX_RECORDS)) u_sln_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
